// ===== hdl/ecl_pkg.sv =====
// Package for the cross-entropy loss core: default sizes, fixed-point constants,
// configuration register indexes and reset values, and the exp table builder.
// No dependencies.
`default_nettype none
package ecl_pkg;

    localparam int MAX_VOCAB_DEF      = 4096;
    localparam int EXP_TABLE_BITS_DEF = 10;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_IGNORE_INDEX = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MEAN_MODE    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_VOCAB_SIZE   = 2'd2;

    localparam logic signed [31:0] IGNORE_RST = -32'sd100;
    localparam logic               MEAN_RST   = 1'b1;
    localparam logic [12:0]        VOCAB_RST  = 13'd4096;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        x = v;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry b holds 2^-(2^-(etb-b)) in Q0.32
    function automatic logic [15:0][31:0] pow_table(input int etb);
        logic [63:0] c;
        logic [15:0][31:0] tab;
        tab = '0;
        c = isqrt64(64'h1 << 63);
        for (int k = 1; k <= 16; k++) begin
            if (k > 1) begin
                c = isqrt64(c << 32);
            end
            if (k <= etb) begin
                tab[etb-k] = c[31:0];
            end
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ecl_fifo.sv =====
// Two-entry job queue between the front and back parts of the loss core.
// Depends on nothing.
`default_nettype none
module ecl_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      rdata
);
    logic [W-1:0] mem [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = mem[rp_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ecl_front.sv =====
// Front part of the loss core: accepts logits, stores the row, tracks max and
// target, classifies finished rows into jobs. Depends on ecl_pkg.
`default_nettype none
module ecl_front #(
    parameter int MAX_VOCAB = ecl_pkg::MAX_VOCAB_DEF,
    localparam int AW = $clog2(MAX_VOCAB),
    localparam int NW = $clog2(MAX_VOCAB + 1),
    localparam int JW = 3 + NW + 32 + AW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] logit,
    input  wire logic signed [31:0] target,
    input  wire logic               last_token,
    input  wire logic signed [31:0] skip_index,
    input  wire logic [12:0]        row_len,
    output logic                    job_push,
    output logic [JW-1:0]           job_data,
    input  wire logic               job_full,
    input  wire logic               mem_done,
    input  wire logic [AW-1:0]      rd_addr,
    output logic [31:0]             rd_data
);
    import ecl_pkg::*;

    typedef struct packed {
        logic              sum;
        logic              err;
        logic              emit;
        logic [NW-1:0]     n;
        logic signed [31:0] mx;
        logic [AW-1:0]     tgt;
    } job_t;

    logic [31:0]        mem [MAX_VOCAB];
    logic [31:0]        rd_data_reg;
    logic [AW-1:0]      cnt_reg;
    logic signed [31:0] max_reg;
    logic signed [31:0] tgt_reg;
    logic               pend_reg;

    logic               acc;
    logic               first;
    logic [NW-1:0]      eff;
    logic [NW-1:0]      n;
    logic               row_end;
    logic signed [31:0] tgt_row;
    logic signed [31:0] max_row;
    logic               ign;
    logic               bad;
    job_t               job;

    assign in_ready = !job_full && !pend_reg;
    assign acc      = in_valid && in_ready;
    assign rd_data  = rd_data_reg;

    always_comb begin
        if (row_len == 13'd0) begin
            eff = NW'(1);
        end else if (32'(row_len) > 32'(MAX_VOCAB)) begin
            eff = NW'(MAX_VOCAB);
        end else begin
            eff = NW'(row_len);
        end
        first   = (cnt_reg == '0);
        n       = NW'(cnt_reg) + NW'(1);
        row_end = (n >= eff);
        tgt_row = first ? target : tgt_reg;
        max_row = (first || (logit > max_reg)) ? logit : max_reg;
        ign     = (tgt_row == skip_index);
        bad     = !ign && ((tgt_row < 0) || ($unsigned(tgt_row) >= 32'(n)));
        job.sum  = row_end && !ign && !bad;
        job.err  = row_end && bad;
        job.emit = last_token;
        job.n    = n;
        job.mx   = max_row;
        job.tgt  = tgt_row[AW-1:0];
    end

    assign job_data = job;
    assign job_push = acc && (job.sum || job.err || job.emit);

    always_ff @(posedge clk) begin
        if (acc) begin
            mem[cnt_reg] <= logit;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            max_reg  <= 32'sh8000_0000;
            tgt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (mem_done) begin
                pend_reg <= 1'b0;
            end
            if (acc) begin
                tgt_reg <= tgt_row;
                if (job.sum) begin
                    pend_reg <= 1'b1;
                end
                if (row_end || last_token) begin
                    cnt_reg <= '0;
                    max_reg <= 32'sh8000_0000;
                end else begin
                    cnt_reg <= cnt_reg + AW'(1);
                    max_reg <= max_row;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ecl_back.sv =====
// Back part of the loss core: runs row jobs (exp sum, log, accumulate), error jobs
// (set status) and result jobs (mean divide, saturate). Depends on ecl_pkg.
`default_nettype none
module ecl_back #(
    parameter int MAX_VOCAB      = ecl_pkg::MAX_VOCAB_DEF,
    parameter int EXP_TABLE_BITS = ecl_pkg::EXP_TABLE_BITS_DEF,
    localparam int AW = $clog2(MAX_VOCAB),
    localparam int NW = $clog2(MAX_VOCAB + 1),
    localparam int JW = 3 + NW + 32 + AW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire logic [JW-1:0] job_data,
    output logic               job_pop,
    input  wire logic          mean_mode,
    output logic [AW-1:0]      rd_addr,
    input  wire logic [31:0]   rd_data,
    output logic               mem_done,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [46:0]        loss,
    output logic [31:0]        valid_rows,
    output logic               status
);
    import ecl_pkg::*;

    localparam int SW = 32 + NW;
    localparam int PW = $clog2(SW);
    localparam int LW = PW + 16;
    localparam int BW = $clog2(EXP_TABLE_BITS);
    localparam logic [15:0][31:0] PTAB = pow_table(EXP_TABLE_BITS);
    localparam logic [47:0] ACC_MAX  = '1;
    localparam logic [46:0] LOSS_MAX = '1;

    typedef struct packed {
        logic              sum;
        logic              err;
        logic              emit;
        logic [NW-1:0]     n;
        logic signed [31:0] mx;
        logic [AW-1:0]     tgt;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE, S_TRD, S_TCAP, S_ERD, S_ECAP, S_EPOW, S_EADD,
        S_NORM, S_SQR, S_LNM, S_ACC, S_EMIT, S_DIV, S_OUT
    } state_t;

    state_t             state_reg;
    job_t               job_reg;
    job_t               job_in;
    logic signed [31:0] xt_reg;
    logic [AW-1:0]      j_reg;
    logic [32:0]        t_reg;
    logic [32:0]        m_reg;
    logic [BW-1:0]      b_reg;
    logic [SW-1:0]      s_reg;
    logic [PW-1:0]      p_reg;
    logic [31:0]        z_reg;
    logic [LW-1:0]      l_reg;
    logic [3:0]         i_reg;
    logic [LW-1:0]      ln_reg;
    logic [47:0]        acc_reg;
    logic [31:0]        cnt_reg;
    logic               err_reg;
    logic [48:0]        dvd_reg;
    logic [31:0]        div_reg;
    logic [31:0]        rem_reg;
    logic [48:0]        q_reg;
    logic [5:0]         k_reg;
    logic               out_valid_reg;
    logic [46:0]        loss_reg;
    logic [31:0]        rows_reg;
    logic               status_reg;

    logic [32:0]              d_diff;
    logic [48:0]              t_full;
    logic [64:0]              pow_prod;
    logic [EXP_TABLE_BITS-1:0] frac;
    logic                     big;
    logic                     last_elem;
    logic [63:0]              sq;
    logic [32:0]              zz;
    logic [LW+32:0]           lnp;
    logic [32:0]              dmx;
    logic [49:0]              acc_sum;
    logic [32:0]              rem_sh;
    logic                     ge;
    logic [48:0]              qf;

    assign job_in    = job_data;
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign rd_addr   = (state_reg == S_TRD) ? job_reg.tgt : j_reg;
    assign last_elem = (NW'(j_reg) == job_reg.n - NW'(1));
    assign mem_done  = (state_reg == S_EADD) && last_elem;
    assign out_valid  = out_valid_reg;
    assign loss       = loss_reg;
    assign valid_rows = rows_reg;
    assign status     = status_reg;

    always_comb begin
        d_diff   = 33'(job_reg.mx) - 33'($signed(rd_data));
        t_full   = 49'(d_diff[31:0]) * 49'(LOG2E_Q16);
        frac     = t_reg[15 -: EXP_TABLE_BITS];
        big      = |t_reg[32:21];
        pow_prod = 65'(m_reg) * 65'(PTAB[4'(b_reg)]) + 65'(33'h0_8000_0000);
        sq       = 64'(z_reg) * 64'(z_reg);
        zz       = sq[63:31];
        lnp      = (LW+33)'(l_reg) * (LW+33)'(LN2_Q32) + (LW+33)'(33'h0_8000_0000);
        dmx      = 33'(job_reg.mx) - 33'(xt_reg);
        acc_sum  = 50'(acc_reg) + 50'(ln_reg) + 50'(dmx);
        rem_sh   = {1'b0, rem_reg[30:0], dvd_reg[48]} | {rem_reg[31], 32'd0};
        ge       = (rem_sh >= 33'(div_reg));
        qf       = {q_reg[47:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            xt_reg        <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
            m_reg         <= '0;
            b_reg         <= '0;
            s_reg         <= '0;
            p_reg         <= '0;
            z_reg         <= '0;
            l_reg         <= '0;
            i_reg         <= '0;
            ln_reg        <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            dvd_reg       <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            loss_reg      <= '0;
            rows_reg      <= '0;
            status_reg    <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job_in;
                        if (job_in.sum) begin
                            state_reg <= S_TRD;
                        end else begin
                            if (job_in.err) begin
                                err_reg <= 1'b1;
                            end
                            if (job_in.emit) begin
                                state_reg <= S_EMIT;
                            end
                        end
                    end
                end
                S_TRD: begin
                    state_reg <= S_TCAP;
                end
                S_TCAP: begin
                    xt_reg    <= rd_data;
                    j_reg     <= '0;
                    s_reg     <= '0;
                    state_reg <= S_ERD;
                end
                S_ERD: begin
                    state_reg <= S_ECAP;
                end
                S_ECAP: begin
                    t_reg     <= t_full[48:16];
                    m_reg     <= 33'h1_0000_0000;
                    b_reg     <= '0;
                    state_reg <= S_EPOW;
                end
                S_EPOW: begin
                    if (frac[b_reg]) begin
                        m_reg <= pow_prod[64:32];
                    end
                    if (b_reg == BW'(EXP_TABLE_BITS - 1)) begin
                        state_reg <= S_EADD;
                    end else begin
                        b_reg <= b_reg + BW'(1);
                    end
                end
                S_EADD: begin
                    if (!big) begin
                        s_reg <= s_reg + SW'(m_reg >> t_reg[20:16]);
                    end
                    if (last_elem) begin
                        p_reg     <= PW'(SW - 1);
                        state_reg <= S_NORM;
                    end else begin
                        j_reg     <= j_reg + AW'(1);
                        state_reg <= S_ERD;
                    end
                end
                S_NORM: begin
                    if (s_reg[SW-1]) begin
                        z_reg     <= s_reg[SW-1 -: 32];
                        l_reg     <= LW'(p_reg - PW'(32)) << 16;
                        i_reg     <= 4'd15;
                        state_reg <= S_SQR;
                    end else begin
                        s_reg <= s_reg << 1;
                        p_reg <= p_reg - PW'(1);
                    end
                end
                S_SQR: begin
                    if (zz[32]) begin
                        z_reg        <= zz[32:1];
                        l_reg[i_reg] <= 1'b1;
                    end else begin
                        z_reg <= zz[31:0];
                    end
                    if (i_reg == 4'd0) begin
                        state_reg <= S_LNM;
                    end else begin
                        i_reg <= i_reg - 4'd1;
                    end
                end
                S_LNM: begin
                    ln_reg    <= lnp[LW+31:32];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= (acc_sum > 50'(ACC_MAX)) ? ACC_MAX : acc_sum[47:0];
                    if (cnt_reg != 32'hFFFF_FFFF) begin
                        cnt_reg <= cnt_reg + 32'd1;
                    end
                    state_reg <= job_reg.emit ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    rows_reg   <= cnt_reg;
                    status_reg <= err_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                    err_reg    <= 1'b0;
                    if (mean_mode && (cnt_reg != 32'd0)) begin
                        dvd_reg   <= 49'(acc_reg) + 49'(cnt_reg >> 1);
                        div_reg   <= cnt_reg;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        k_reg     <= 6'd48;
                        state_reg <= S_DIV;
                    end else begin
                        if (mean_mode) begin
                            loss_reg <= '0;
                        end else begin
                            loss_reg <= (|acc_reg[47]) ? LOSS_MAX : acc_reg[46:0];
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_DIV: begin
                    rem_reg <= ge ? 32'(rem_sh - 33'(div_reg)) : rem_sh[31:0];
                    q_reg   <= qf;
                    dvd_reg <= dvd_reg << 1;
                    if (k_reg == 6'd0) begin
                        loss_reg      <= (|qf[48:47]) ? LOSS_MAX : qf[46:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        k_reg <= k_reg - 6'd1;
                    end
                end
                S_OUT: begin
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/cross_entropy_loss_core.sv =====
// Top level of the softmax cross-entropy loss core: configuration registers,
// front part, job queue, back part. Depends on ecl_pkg, ecl_front, ecl_fifo, ecl_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  input     | s_tvalid/s_tready  | s_tdata {target, logit}, s_tlast last_token
//  result    | m_tvalid/m_tready  | m_tdata {valid_rows, loss}, m_tuser status
//  config    | cfg_we             | cfg_addr index, cfg_data value
//
// A logit is stored as it is accepted; a finished row is then read back: the
// target logit is fetched, each logit gets one exp multiply per table bit and
// is added to the sum, the sum is normalized and squared 16 times for the log,
// and the log is scaled by ln 2 and accumulated.
// Input stalls while a row is read back from the row memory or the job queue is full.
// A mean result is then divided in the restoring divider.
// Reset clears all control state; the row memory is not cleared.
`default_nettype none
module cross_entropy_loss_core #(
    parameter int MAX_VOCAB      = ecl_pkg::MAX_VOCAB_DEF,
    parameter int EXP_TABLE_BITS = ecl_pkg::EXP_TABLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // logit[31:0], target[63:32]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // loss[46:0], valid_rows[78:47], zero[79]
    output logic             m_tuser,   // status[0]
    input  wire logic        cfg_we,
    input  wire logic [ecl_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [31:0] cfg_data
);
    import ecl_pkg::*;

    localparam int AW = $clog2(MAX_VOCAB);
    localparam int NW = $clog2(MAX_VOCAB + 1);
    localparam int JW = 3 + NW + 32 + AW;

    logic signed [31:0] ignore_reg;
    logic               mean_reg;
    logic [12:0]        vocab_reg;

    logic          push;
    logic [JW-1:0] wdata;
    logic          full;
    logic          pop;
    logic          not_empty;
    logic [JW-1:0] rdata;
    logic          mem_done;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [46:0]   loss;
    logic [31:0]   valid_rows;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ignore_reg <= IGNORE_RST;
            mean_reg   <= MEAN_RST;
            vocab_reg  <= VOCAB_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_IGNORE_INDEX: ignore_reg <= cfg_data;
                CFG_MEAN_MODE:    mean_reg   <= cfg_data[0];
                CFG_VOCAB_SIZE:   vocab_reg  <= cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    ecl_front #(.MAX_VOCAB(MAX_VOCAB)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .logit        (s_tdata[31:0]),
        .target       (s_tdata[63:32]),
        .last_token   (s_tlast),
        .skip_index   (ignore_reg),
        .row_len      (vocab_reg),
        .job_push     (push),
        .job_data     (wdata),
        .job_full     (full),
        .mem_done     (mem_done),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    ecl_fifo #(.W(JW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (wdata),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rdata     (rdata)
    );

    ecl_back #(.MAX_VOCAB(MAX_VOCAB), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (not_empty),
        .job_data   (rdata),
        .job_pop    (pop),
        .mean_mode  (mean_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .mem_done   (mem_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .loss       (loss),
        .valid_rows (valid_rows),
        .status     (m_tuser)
    );

    assign m_tdata = {1'b0, valid_rows, loss};
endmodule
`default_nettype wire

// ===== hdl/ecl_checker.sv =====
// Port-level checks for the loss core, bound to the top level.
// Depends on cross_entropy_loss_core.
`default_nettype none
module ecl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[79])
        else $error("pad bit set");

    a_norows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[78:47] == 32'd0) |-> (m_tdata[46:0] == 47'd0))
        else $error("loss without rows");

    a_rst: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result during reset");
endmodule

bind cross_entropy_loss_core ecl_checker u_ecl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
